/* design/rcws_pkg.sv */
// shared types, codes and constants of the range checked window statistics block
package rcws_pkg;

    // default sizes
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // fixed field widths
    localparam int MINUTE_W = 11;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes
    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_ENABLED    = 2'd2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_OFF   = 2'd2
    } t_status;

    // microprogram step addresses
    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_RD_OLD     = 3'd1,
        ST_UPDATE     = 3'd2,
        ST_SCAN_START = 3'd3,
        ST_SCAN       = 3'd4,
        ST_DIV_WAIT   = 3'd5,
        ST_OUT        = 3'd6,
        ST_RETURN     = 3'd7
    } t_step;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_WAIT_IN    = 3'd1,
        OP_RD_OLD     = 3'd2,
        OP_UPDATE     = 3'd3,
        OP_SCAN_START = 3'd4,
        OP_SCAN       = 3'd5,
        OP_OUTPUT     = 3'd6
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_ACCEPT = 3'd2,
        C_EMPTY     = 3'd3,
        C_SCAN_MORE = 3'd4,
        C_DIV_BUSY  = 3'd5,
        C_OUT_FULL  = 3'd6
    } t_cond;

    // one control word of the microprogram
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // status flags from the datapath to the sequencer
    typedef struct packed {
        logic accept;
        logic empty;
        logic scan_more;
        logic div_busy;
        logic out_full;
    } t_flags;

endpackage

/* design/rcws_if.sv */
// item channels of the window statistics block: sample in, result out
interface rcws_in_if
    import rcws_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic        [MINUTE_W-1:0]     minute_of_day;

    modport source (output valid, sample, minute_of_day, input ready);
    modport sink   (input valid, sample, minute_of_day, output ready);
endinterface

interface rcws_out_if
    import rcws_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic        [STATUS_W-1:0]     status;
    logic signed [SAMPLE_WIDTH-1:0] value_out;
    logic        [MINUTE_W-1:0]     minute_out;
    logic                           has_history;
    logic signed [SAMPLE_WIDTH-1:0] window_min;
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic signed [SAMPLE_WIDTH-1:0] window_mean;

    modport source (output valid, status, value_out, minute_out, has_history,
                    window_min, window_max, window_mean, input ready);
    modport sink   (input valid, status, value_out, minute_out, has_history,
                    window_min, window_max, window_mean, output ready);
endinterface

/* design/rcws_ram.sv */
// generic single write, single read ram with registered read data
module rcws_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rcws_seq.sv */
// microprogram sequencer: step counter, control store and conditional jumps
module rcws_seq
    import rcws_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step r_step;
    t_step n_step;
    logic  take;

    // control store, one word per step
    function automatic t_ctrl ucode_rom(t_step step);
        t_ctrl w;
        case (step)
            ST_IDLE:       w = '{op: OP_WAIT_IN,    cond: C_NO_ACCEPT, target: ST_IDLE};
            ST_RD_OLD:     w = '{op: OP_RD_OLD,     cond: C_NEVER,     target: ST_IDLE};
            ST_UPDATE:     w = '{op: OP_UPDATE,     cond: C_NEVER,     target: ST_IDLE};
            ST_SCAN_START: w = '{op: OP_SCAN_START, cond: C_EMPTY,     target: ST_DIV_WAIT};
            ST_SCAN:       w = '{op: OP_SCAN,       cond: C_SCAN_MORE, target: ST_SCAN};
            ST_DIV_WAIT:   w = '{op: OP_NONE,       cond: C_DIV_BUSY,  target: ST_DIV_WAIT};
            ST_OUT:        w = '{op: OP_OUTPUT,     cond: C_OUT_FULL,  target: ST_OUT};
            ST_RETURN:     w = '{op: OP_NONE,       cond: C_ALWAYS,    target: ST_IDLE};
            default:       w = '{op: OP_NONE,       cond: C_ALWAYS,    target: ST_IDLE};
        endcase
        return w;
    endfunction

    // control word of the current step
    always_comb begin
        o_ctrl = ucode_rom(r_step);
    end

    // jump or fall through
    always_comb begin
        case (o_ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = !i_flags.accept;
            C_EMPTY:     take = i_flags.empty;
            C_SCAN_MORE: take = i_flags.scan_more;
            C_DIV_BUSY:  take = i_flags.div_busy;
            C_OUT_FULL:  take = i_flags.out_full;
            default:     take = 1'b1;
        endcase
        n_step = take ? o_ctrl.target : t_step'(r_step + 3'd1);
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* design/rcws_dp.sv */
// datapath: range check, window update, min and max scan, serial divider, output register
module rcws_dp
    import rcws_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctrl                          i_ctrl,
    output t_flags                         o_flags,
    rcws_in_if.sink                        i_in,
    rcws_out_if.source                     o_out,
    input  logic signed [SAMPLE_WIDTH-1:0] i_range_low,
    input  logic signed [SAMPLE_WIDTH-1:0] i_range_high,
    input  logic                           i_enabled
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);

    // control state
    logic [ADDR_W-1:0]        r_wptr;
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_rd_idx;
    logic                     r_div_busy;
    logic [DCNT_W-1:0]        r_div_cnt;
    logic                     r_out_valid;

    // item and working payload
    t_status                        r_status;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic        [MINUTE_W-1:0]     r_minute;
    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic signed [SAMPLE_WIDTH-1:0] r_max;
    logic        [SUM_W-1:0]        r_div_q;
    logic        [CNT_W-1:0]        r_div_rem;
    logic                           r_div_neg;

    // output register
    t_status                        r_o_status;
    logic signed [SAMPLE_WIDTH-1:0] r_o_value;
    logic        [MINUTE_W-1:0]     r_o_minute;
    logic                           r_o_hist;
    logic signed [SAMPLE_WIDTH-1:0] r_o_min;
    logic signed [SAMPLE_WIDTH-1:0] r_o_max;
    logic signed [SAMPLE_WIDTH-1:0] r_o_mean;

    logic                           accept;
    logic                           in_range;
    logic                           full;
    logic                           out_full;
    logic                           load_out;
    logic                           scan_more;
    logic                           ram_we;
    logic                           ram_re;
    logic [ADDR_W-1:0]              ram_raddr;
    logic [SAMPLE_WIDTH-1:0]        ram_rdata;
    logic signed [SAMPLE_WIDTH-1:0] rd_val;
    logic [SUM_W-1:0]               n_mag;
    logic [CNT_W:0]                 rem_sh;
    logic [CNT_W:0]                 rem_diff;
    logic                           rem_ge;
    logic [SUM_W-1:0]               q_fixed;
    logic signed [SAMPLE_WIDTH-1:0] n_mean;

    // handshake and flags
    assign i_in.ready = (i_ctrl.op == OP_WAIT_IN);
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == FULL_CNT);
    assign scan_more  = (r_rd_idx < r_count);
    assign out_full   = r_out_valid && !o_out.ready;
    assign load_out   = (i_ctrl.op == OP_OUTPUT) && !out_full;

    always_comb begin
        o_flags.accept    = accept;
        o_flags.empty     = (r_count == '0);
        o_flags.scan_more = scan_more;
        o_flags.div_busy  = r_div_busy;
        o_flags.out_full  = out_full;
    end

    // plausibility check, inclusive at both ends
    assign in_range = (i_in.sample >= i_range_low) && (i_in.sample <= i_range_high);

    // window store ports
    always_comb begin
        ram_we    = (i_ctrl.op == OP_UPDATE) && (r_status == STATUS_VALID);
        ram_re    = 1'b0;
        ram_raddr = r_wptr;
        case (i_ctrl.op)
            OP_RD_OLD: begin
                ram_re    = 1'b1;
                ram_raddr = r_wptr;
            end
            OP_SCAN_START: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            OP_SCAN: begin
                ram_re    = scan_more;
                ram_raddr = r_rd_idx[ADDR_W-1:0];
            end
            default: begin
                ram_re    = 1'b0;
                ram_raddr = r_wptr;
            end
        endcase
    end

    rcws_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val = $signed(ram_rdata);

    // divider step: shift in one dividend bit, subtract the count when it fits
    assign n_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign rem_sh   = {r_div_rem, r_div_q[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_count});
    assign rem_diff = rem_sh - {1'b0, r_count};

    // sign of the quotient follows the sum, truncation toward zero
    assign q_fixed = r_div_neg ? (~r_div_q + SUM_W'(1)) : r_div_q;
    assign n_mean  = (r_count == '0) ? '0 : q_fixed[SAMPLE_WIDTH-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_rd_idx    <= '0;
            r_div_busy  <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // window update with the oldest entry dropped when full
            if ((i_ctrl.op == OP_UPDATE) && (r_status == STATUS_VALID)) begin
                if (full) begin
                    r_sum <= r_sum - SUM_W'(rd_val) + SUM_W'(r_sample);
                end else begin
                    r_sum   <= r_sum + SUM_W'(r_sample);
                    r_count <= r_count + CNT_W'(1);
                end
                r_wptr <= (r_wptr == LAST_ADDR) ? '0 : r_wptr + ADDR_W'(1);
            end
            // scan index, one entry a cycle
            if (i_ctrl.op == OP_SCAN_START) begin
                r_rd_idx <= CNT_W'(1);
            end else if (i_ctrl.op == OP_SCAN) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            // divider runs beside the scan
            if (i_ctrl.op == OP_SCAN_START) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DCNT_W'(SUM_W);
            end else if (r_div_busy) begin
                r_div_cnt  <= r_div_cnt - DCNT_W'(1);
                r_div_busy <= (r_div_cnt != DCNT_W'(1));
            end
            // output register
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // capture and classify the item
        if (accept) begin
            if (!i_enabled) begin
                r_status <= STATUS_OFF;
                r_sample <= '0;
                r_minute <= '0;
            end else begin
                r_status <= in_range ? STATUS_VALID : STATUS_RANGE;
                r_sample <= i_in.sample;
                r_minute <= i_in.minute_of_day;
            end
        end
        // min and max over the valid entries
        if (i_ctrl.op == OP_SCAN_START) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_ctrl.op == OP_SCAN) begin
            if (r_rd_idx == CNT_W'(1)) begin
                r_min <= rd_val;
                r_max <= rd_val;
            end else begin
                if (rd_val < r_min) begin
                    r_min <= rd_val;
                end
                if (rd_val > r_max) begin
                    r_max <= rd_val;
                end
            end
        end
        // divider registers
        if (i_ctrl.op == OP_SCAN_START) begin
            r_div_q   <= n_mag;
            r_div_rem <= '0;
            r_div_neg <= r_sum[SUM_W-1];
        end else if (r_div_busy) begin
            r_div_q   <= {r_div_q[SUM_W-2:0], rem_ge};
            r_div_rem <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
        // result item
        if (load_out) begin
            r_o_status <= r_status;
            r_o_value  <= r_sample;
            r_o_minute <= r_minute;
            r_o_hist   <= (r_count != '0);
            r_o_min    <= r_min;
            r_o_max    <= r_max;
            r_o_mean   <= n_mean;
        end
    end

    // result channel
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_o_status;
    assign o_out.value_out   = r_o_value;
    assign o_out.minute_out  = r_o_minute;
    assign o_out.has_history = r_o_hist;
    assign o_out.window_min  = r_o_min;
    assign o_out.window_max  = r_o_max;
    assign o_out.window_mean = r_o_mean;

endmodule

/* design/range_checked_window_stats.sv */
// Range checked window statistics. Each sample item is checked against the
// programmed plausible range; an in-range sample enters a window of the last
// WINDOW_DEPTH valid samples, and every item gives one result with its status
// and the window's minimum, maximum and truncated mean. One item is worked on
// at a time under a small microprogram. The minimum and maximum come from a
// scan of the window memory at one entry per cycle through its single read
// port, and a restoring divider beside the scan takes one quotient bit per
// cycle (SAMPLE_WIDTH + log2 WINDOW_DEPTH steps, 22 by default). The result
// waits in an output register, so the next item is taken while it is still
// unclaimed. Registers lie at byte addresses 0 (range_low), 4 (range_high)
// and 8 (sensor_enabled); the user writes them only while the block is idle,
// and the block itself does not enforce this. The window memory needs no
// clearing after reset.
module range_checked_window_stats
    import rcws_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rcws_in_if.sink            i_in,
    rcws_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic signed [SAMPLE_WIDTH-1:0] r_range_low;
    logic signed [SAMPLE_WIDTH-1:0] r_range_high;
    logic                           r_enabled;
    logic                           cfg_wr;
    logic [1:0]                     cfg_idx;
    t_ctrl                          ctrl;
    t_flags                         flags;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            r_enabled    <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RANGE_LOW:  r_range_low  <= pwdata[SAMPLE_WIDTH-1:0];
                REG_RANGE_HIGH: r_range_high <= pwdata[SAMPLE_WIDTH-1:0];
                REG_ENABLED:    r_enabled    <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // register read back, signed ranges sign extended
    always_comb begin
        case (cfg_idx)
            REG_RANGE_LOW:  prdata = PDATA_W'(r_range_low);
            REG_RANGE_HIGH: prdata = PDATA_W'(r_range_high);
            REG_ENABLED:    prdata = PDATA_W'(r_enabled);
            default:        prdata = '0;
        endcase
    end

    // microprogram control
    rcws_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    // datapath and window store
    rcws_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_flags      (flags),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_range_low  (r_range_low),
        .i_range_high (r_range_high),
        .i_enabled    (r_enabled)
    );

endmodule

/* design/rcws_chk.sv */
// port level checks of the window statistics block and their binding
module rcws_chk
    import rcws_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic        [STATUS_W-1:0]     i_status,
    input logic signed [SAMPLE_WIDTH-1:0] i_value,
    input logic        [MINUTE_W-1:0]     i_minute,
    input logic                           i_hist,
    input logic signed [SAMPLE_WIDTH-1:0] i_min,
    input logic signed [SAMPLE_WIDTH-1:0] i_max,
    input logic signed [SAMPLE_WIDTH-1:0] i_mean
);

    // a stalled result stays valid and keeps its status, value and mean
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_value)
            && $stable(i_mean))
        else $error("stalled result changed");

    // disabled sensor reports no sample and no minute
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == STATUS_OFF) |-> (i_value == '0) && (i_minute == '0))
        else $error("disabled item carries a sample");

    // empty window gives zero statistics
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hist |-> (i_min == '0) && (i_max == '0) && (i_mean == '0))
        else $error("empty window with nonzero statistics");

    // an accepted sample leaves the window non-empty
    a_valid_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == STATUS_VALID) |-> i_hist)
        else $error("valid sample without history");

    // mean lies between minimum and maximum
    a_mean_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_hist |-> (i_min <= i_mean) && (i_mean <= i_max))
        else $error("mean outside window range");

endmodule

bind range_checked_window_stats rcws_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rcws_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_status (o_out.status),
    .i_value  (o_out.value_out),
    .i_minute (o_out.minute_out),
    .i_hist   (o_out.has_history),
    .i_min    (o_out.window_min),
    .i_max    (o_out.window_max),
    .i_mean   (o_out.window_mean)
);
